FILE: rtl/hs5_pkg.sv
`default_nettype none
package hs5_pkg;

    localparam int DATA_W          = 32;
    localparam int GAIN_W          = 16;
    localparam int COLS_W          = 11;
    localparam int ROWS_W          = 16;
    localparam int FRAC_BITS       = 16;
    localparam int DEF_MAX_COLUMNS = 1024;

    // laplacian needs three guard bits, product adds the unsigned gain
    localparam int LAP_W  = DATA_W + 3;
    localparam int PROD_W = LAP_W + GAIN_W + 1;
    localparam int SUM_W  = PROD_W - FRAC_BITS + 1;

    localparam int QUEUE_DEPTH = 4;
    localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
    localparam int QPTR_W      = $clog2(QUEUE_DEPTH);

    localparam int PADDR_W = 4;
    localparam int PDATA_W = 32;

    localparam int MIN_COLUMNS = 3;
    localparam logic [ROWS_W-1:0] MIN_ROWS = ROWS_W'(3);

    localparam logic [COLS_W-1:0] RESET_COLUMNS = COLS_W'(1024);
    localparam logic [ROWS_W-1:0] RESET_ROWS    = ROWS_W'(1024);
    localparam logic [GAIN_W-1:0] RESET_GAIN    = GAIN_W'(16384);

    typedef enum logic [1:0] {
        REG_COLUMNS = 2'd0,
        REG_ROWS    = 2'd1,
        REG_GAIN    = 2'd2
    } reg_idx_t;

    // one classified request handed from the front to the back
    typedef struct packed {
        logic [DATA_W-1:0] centre;
        logic [DATA_W-1:0] north;
        logic [DATA_W-1:0] east;
        logic [DATA_W-1:0] west;
        logic [DATA_W-1:0] south;
        logic              has_a;
        logic              pass_a;
        logic              has_b;
        logic              b_end;
    } hs5_entry_t;

    function automatic logic [DATA_W-1:0] sat_value(input logic [SUM_W-1:0] v);
        logic fits;
        logic [DATA_W-1:0] res;
        fits = (&v[SUM_W-1:DATA_W-1]) || ~(|v[SUM_W-1:DATA_W-1]);
        if (fits)
        begin
            res = v[DATA_W-1:0];
        end
        else if (v[SUM_W-1])
        begin
            res = {1'b1, {(DATA_W-1){1'b0}}};
        end
        else
        begin
            res = {1'b0, {(DATA_W-1){1'b1}}};
        end
        return res;
    endfunction

endpackage
`default_nettype wire

FILE: rtl/hs5_ram.sv
`default_nettype none
module hs5_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 1024,
    localparam int AW = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // read returns the old contents on a same-address write
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    assign rdata = rdata_reg;

endmodule
`default_nettype wire

FILE: rtl/hs5_front.sv
`default_nettype none
module hs5_front
    import hs5_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS,
    localparam int AW = $clog2(MAX_COLUMNS),
    localparam int CNT_W = $clog2(MAX_COLUMNS + 1)
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              item_valid,
    output logic              item_stall,
    input  logic [DATA_W-1:0] old_value,
    input  logic [CNT_W-1:0]  eff_cols,
    input  logic [ROWS_W-1:0] eff_rows,
    input  logic              restart,
    input  logic [QCNT_W-1:0] queue_count,
    output logic              push,
    output hs5_entry_t        entry
);

    localparam int QS_W = QCNT_W + 1;

    logic              accept;
    logic [AW-1:0]     col_reg;
    logic [ROWS_W-1:0] row_reg;
    logic [CNT_W-1:0]  col_plus;
    logic              last_col;
    logic              last_row;
    logic [AW-1:0]     east_addr;

    logic              s1_valid_reg;
    logic [DATA_W-1:0] s1_south_reg;
    logic [AW-1:0]     s1_col_reg;
    logic              s1_has_a_reg;
    logic              s1_pass_reg;
    logic              s1_has_b_reg;
    logic              s1_end_reg;
    logic [DATA_W-1:0] west_reg;

    logic [DATA_W-1:0] mid_c_rdata;
    logic [DATA_W-1:0] mid_e_rdata;
    logic [DATA_W-1:0] up_rdata;

    // room is held for the request still in the read stage
    assign item_stall = (QS_W'(queue_count) + QS_W'(s1_valid_reg)) >= QS_W'(QUEUE_DEPTH);
    assign accept     = item_valid && !item_stall;

    assign col_plus  = CNT_W'(col_reg) + CNT_W'(1);
    assign last_col  = (col_plus == eff_cols);
    assign last_row  = ((row_reg + ROWS_W'(1)) == eff_rows);
    assign east_addr = AW'(col_plus);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (restart)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            if (last_col)
            begin
                col_reg <= '0;
                row_reg <= last_row ? '0 : row_reg + ROWS_W'(1);
            end
            else
            begin
                col_reg <= AW'(col_plus);
            end
        end
    end

    // two copies of the previous row give centre and east in the same cycle
    hs5_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLUMNS)) u_mid_c (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (old_value),
        .re    (accept),
        .raddr (col_reg),
        .rdata (mid_c_rdata)
    );

    hs5_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLUMNS)) u_mid_e (
        .clk   (clk),
        .we    (accept),
        .waddr (col_reg),
        .wdata (old_value),
        .re    (accept),
        .raddr (east_addr),
        .rdata (mid_e_rdata)
    );

    hs5_ram #(.WIDTH(DATA_W), .DEPTH(MAX_COLUMNS)) u_upper (
        .clk   (clk),
        .we    (s1_valid_reg),
        .waddr (s1_col_reg),
        .wdata (mid_c_rdata),
        .re    (accept),
        .raddr (col_reg),
        .rdata (up_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg <= 1'b0;
            west_reg     <= '0;
        end
        else
        begin
            s1_valid_reg <= accept;
            if (s1_valid_reg)
            begin
                west_reg <= mid_c_rdata;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_south_reg <= old_value;
            s1_col_reg   <= col_reg;
            s1_has_a_reg <= (row_reg != '0);
            s1_pass_reg  <= (row_reg == ROWS_W'(1)) || (col_reg == '0) || last_col;
            s1_has_b_reg <= last_row;
            s1_end_reg   <= last_row && last_col;
        end
    end

    // first-row requests only refresh the line stores
    assign push = s1_valid_reg && (s1_has_a_reg || s1_has_b_reg);

    always_comb
    begin
        entry.centre = mid_c_rdata;
        entry.north  = up_rdata;
        entry.east   = mid_e_rdata;
        entry.west   = west_reg;
        entry.south  = s1_south_reg;
        entry.has_a  = s1_has_a_reg;
        entry.pass_a = s1_pass_reg;
        entry.has_b  = s1_has_b_reg;
        entry.b_end  = s1_end_reg;
    end

    a_read_follows: assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("read stage missed an accepted request");

    a_push_room: assert property (@(posedge clk) disable iff (!rst_n)
        push |-> (queue_count < QCNT_W'(QUEUE_DEPTH)))
        else $error("push into a full queue");

endmodule
`default_nettype wire

FILE: rtl/hs5_queue.sv
`default_nettype none
module hs5_queue
    import hs5_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              push,
    input  hs5_entry_t        push_entry,
    input  logic              pop,
    output hs5_entry_t        head_entry,
    output logic              empty,
    output logic [QCNT_W-1:0] count
);

    hs5_entry_t        mem_reg [QUEUE_DEPTH];
    logic [QPTR_W-1:0] wr_ptr_reg;
    logic [QPTR_W-1:0] rd_ptr_reg;
    logic [QCNT_W-1:0] count_reg;
    logic [QCNT_W-1:0] count_next;

    assign empty      = (count_reg == '0);
    assign count      = count_reg;
    assign head_entry = mem_reg[rd_ptr_reg];

    always_comb
    begin
        count_next = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + QCNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - QCNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            count_reg <= count_next;
            if (push)
            begin
                wr_ptr_reg <= wr_ptr_reg + QPTR_W'(1);
            end
            if (pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + QPTR_W'(1);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_entry;
        end
    end

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> !empty)
        else $error("pop from an empty queue");

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= QCNT_W'(QUEUE_DEPTH))
        else $error("queue count beyond depth");

endmodule
`default_nettype wire

FILE: rtl/hs5_back.sv
`default_nettype none
module hs5_back
    import hs5_pkg::*;
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic [GAIN_W-1:0] gain,
    input  logic              q_empty,
    input  hs5_entry_t        q_entry,
    output logic              pop,
    output logic              result_valid,
    input  logic              result_stall,
    output logic [DATA_W-1:0] new_value,
    output logic              frame_end
);

    logic              adv;
    logic              out_free;
    logic              emit_a;
    logic              emit_b;
    logic              p3_done;

    logic              p1_valid_reg;
    logic [LAP_W-1:0]  p1_lap_reg;
    logic [DATA_W-1:0] p1_centre_reg;
    logic [DATA_W-1:0] p1_south_reg;
    logic              p1_has_a_reg;
    logic              p1_pass_reg;
    logic              p1_has_b_reg;
    logic              p1_end_reg;

    logic              p2_valid_reg;
    logic [PROD_W-1:0] p2_prod_reg;
    logic [DATA_W-1:0] p2_centre_reg;
    logic [DATA_W-1:0] p2_south_reg;
    logic              p2_has_a_reg;
    logic              p2_pass_reg;
    logic              p2_has_b_reg;
    logic              p2_end_reg;

    logic              p3_valid_reg;
    logic [DATA_W-1:0] p3_a_reg;
    logic [DATA_W-1:0] p3_b_reg;
    logic              p3_has_a_reg;
    logic              p3_has_b_reg;
    logic              p3_end_reg;
    logic              p3_a_done_reg;

    logic              out_valid_reg;
    logic [DATA_W-1:0] out_value_reg;
    logic              out_end_reg;

    logic [LAP_W-1:0]  centre_x;
    logic [LAP_W-1:0]  lap_next;
    logic [PROD_W-1:0] prod_next;
    logic [SUM_W-1:0]  sum_next;
    logic [DATA_W-1:0] a_next;

    function automatic logic [LAP_W-1:0] sx(input logic [DATA_W-1:0] v);
        return {{(LAP_W-DATA_W){v[DATA_W-1]}}, v};
    endfunction

    assign out_free = !out_valid_reg || !result_stall;

    // final row emits the stencil point first, then its own point
    assign emit_a  = p3_valid_reg && out_free && p3_has_a_reg && !p3_a_done_reg;
    assign emit_b  = p3_valid_reg && out_free && p3_has_b_reg && !emit_a;
    assign p3_done = emit_b || (emit_a && !p3_has_b_reg);
    assign adv     = !p3_valid_reg || p3_done;
    assign pop     = adv && !q_empty;

    assign centre_x = sx(q_entry.centre);

    assign lap_next = sx(q_entry.north) + sx(q_entry.south) + sx(q_entry.east)
                    + sx(q_entry.west) - {centre_x[LAP_W-3:0], 2'b00};

    assign prod_next = PROD_W'($signed(p1_lap_reg) * $signed({1'b0, gain}));

    // floor shift of the product plus centre
    assign sum_next = {p2_prod_reg[PROD_W-1], p2_prod_reg[PROD_W-1:FRAC_BITS]}
                    + {{(SUM_W-DATA_W){p2_centre_reg[DATA_W-1]}}, p2_centre_reg};

    assign a_next = p2_pass_reg ? p2_centre_reg : sat_value(sum_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            p1_valid_reg  <= 1'b0;
            p2_valid_reg  <= 1'b0;
            p3_valid_reg  <= 1'b0;
            p3_a_done_reg <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (adv)
            begin
                p1_valid_reg  <= pop;
                p2_valid_reg  <= p1_valid_reg;
                p3_valid_reg  <= p2_valid_reg;
                p3_a_done_reg <= 1'b0;
            end
            else if (emit_a)
            begin
                p3_a_done_reg <= 1'b1;
            end
            if (out_free)
            begin
                out_valid_reg <= emit_a || emit_b;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            p1_lap_reg    <= lap_next;
            p1_centre_reg <= q_entry.centre;
            p1_south_reg  <= q_entry.south;
            p1_has_a_reg  <= q_entry.has_a;
            p1_pass_reg   <= q_entry.pass_a;
            p1_has_b_reg  <= q_entry.has_b;
            p1_end_reg    <= q_entry.b_end;

            p2_prod_reg   <= prod_next;
            p2_centre_reg <= p1_centre_reg;
            p2_south_reg  <= p1_south_reg;
            p2_has_a_reg  <= p1_has_a_reg;
            p2_pass_reg   <= p1_pass_reg;
            p2_has_b_reg  <= p1_has_b_reg;
            p2_end_reg    <= p1_end_reg;

            p3_a_reg      <= a_next;
            p3_b_reg      <= p2_south_reg;
            p3_has_a_reg  <= p2_has_a_reg;
            p3_has_b_reg  <= p2_has_b_reg;
            p3_end_reg    <= p2_end_reg;
        end
        if (emit_a)
        begin
            out_value_reg <= p3_a_reg;
            out_end_reg   <= 1'b0;
        end
        else if (emit_b)
        begin
            out_value_reg <= p3_b_reg;
            out_end_reg   <= p3_end_reg;
        end
    end

    assign result_valid = out_valid_reg;
    assign new_value    = out_value_reg;
    assign frame_end    = out_end_reg;

    a_second_pending: assert property (@(posedge clk) disable iff (!rst_n)
        p3_a_done_reg |-> (p3_valid_reg && p3_has_b_reg))
        else $error("first result marked done without a second one");

    a_end_on_own_point: assert property (@(posedge clk) disable iff (!rst_n)
        emit_a |=> !out_end_reg)
        else $error("frame end on a stencil result");

endmodule
`default_nettype wire

FILE: rtl/heat_stencil_5pt_update_top.sv
// a result passes the read stage, queue, p1 to p3 and output register; a point
// of row r is released by the request of row r+1, the final row also sends its own
// throughput: one request per cycle while item_stall is low; requests of the final
// row give two results each, sent through the single output register
// reset: counters, west register and all valids clear; line stores keep their
// contents and get no clearing pass
`default_nettype none
module heat_stencil_5pt_update_top
    import hs5_pkg::*;
#(
    parameter int MAX_COLUMNS = DEF_MAX_COLUMNS
) (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 item_valid,
    output logic                 item_stall,
    input  logic [DATA_W-1:0]    old_value,
    output logic                 result_valid,
    input  logic                 result_stall,
    output logic [DATA_W-1:0]    new_value,
    output logic                 frame_end,
    input  logic                 psel,
    input  logic                 penable,
    input  logic                 pwrite,
    input  logic [PADDR_W-1:0]   paddr,
    input  logic [PDATA_W-1:0]   pwdata,
    output logic [PDATA_W-1:0]   prdata,
    output logic                 pready
);

    localparam int CNT_W = $clog2(MAX_COLUMNS + 1);

    logic [COLS_W-1:0] cols_reg;
    logic [ROWS_W-1:0] rows_reg;
    logic [GAIN_W-1:0] gain_reg;
    logic              cfg_write;
    reg_idx_t          cfg_idx;
    logic              restart;
    logic [CNT_W-1:0]  eff_cols;
    logic [ROWS_W-1:0] eff_rows;

    logic              push;
    hs5_entry_t        push_entry;
    logic              pop;
    hs5_entry_t        head_entry;
    logic              q_empty;
    logic [QCNT_W-1:0] q_count;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && pready;
    assign cfg_idx   = reg_idx_t'(paddr[3:2]);
    assign restart   = cfg_write && ((cfg_idx == REG_COLUMNS) || (cfg_idx == REG_ROWS));

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cols_reg <= RESET_COLUMNS;
            rows_reg <= RESET_ROWS;
            gain_reg <= RESET_GAIN;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_COLUMNS: cols_reg <= pwdata[COLS_W-1:0];
                REG_ROWS:    rows_reg <= pwdata[ROWS_W-1:0];
                REG_GAIN:    gain_reg <= pwdata[GAIN_W-1:0];
                default:     ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_COLUMNS: prdata = PDATA_W'(cols_reg);
            REG_ROWS:    prdata = PDATA_W'(rows_reg);
            REG_GAIN:    prdata = PDATA_W'(gain_reg);
            default:     prdata = '0;
        endcase
    end

    // geometry clamped to at least MIN_COLUMNS by MIN_ROWS, columns also to what the line stores hold
    always_comb
    begin
        if (32'(cols_reg) < 32'(MIN_COLUMNS))
        begin
            eff_cols = CNT_W'(MIN_COLUMNS);
        end
        else if (32'(cols_reg) > 32'(MAX_COLUMNS))
        begin
            eff_cols = CNT_W'(MAX_COLUMNS);
        end
        else
        begin
            eff_cols = CNT_W'(cols_reg);
        end
        eff_rows = (rows_reg < MIN_ROWS) ? MIN_ROWS : rows_reg;
    end

    hs5_front #(.MAX_COLUMNS(MAX_COLUMNS)) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .item_valid  (item_valid),
        .item_stall  (item_stall),
        .old_value   (old_value),
        .eff_cols    (eff_cols),
        .eff_rows    (eff_rows),
        .restart     (restart),
        .queue_count (q_count),
        .push        (push),
        .entry       (push_entry)
    );

    hs5_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head_entry (head_entry),
        .empty      (q_empty),
        .count      (q_count)
    );

    hs5_back u_back (
        .clk          (clk),
        .rst_n        (rst_n),
        .gain         (gain_reg),
        .q_empty      (q_empty),
        .q_entry      (head_entry),
        .pop          (pop),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .new_value    (new_value),
        .frame_end    (frame_end)
    );

endmodule
`default_nettype wire

FILE: verif/heat_stencil_5pt_update_top_tb.sv
`timescale 1ns / 100ps
module heat_stencil_5pt_update_top_tb;
    import hs5_pkg::*;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              frame_end;
    } grid_point_t;

    // two 3x3 frames that drive the stencil into both saturation limits
    localparam logic [DATA_W-1:0] EDGE_FRAMES [18] = '{
        32'h00000000, 32'h7FFFFFFF, 32'h00010000,
        32'h7FFFFFFF, 32'h80000000, 32'h7FFFFFFF,
        32'hFFFFFFFF, 32'h7FFFFFFF, 32'h00000001,
        32'h80000000, 32'h80000000, 32'hFFFF0000,
        32'h80000000, 32'h7FFFFFFF, 32'h80000000,
        32'h00000000, 32'h80000000, 32'h55555555
    };

    class stencil_scoreboard;
        int unsigned              columns_reg;
        int unsigned              rows_reg;
        int unsigned              gain_reg;
        logic signed [DATA_W-1:0] upper_row [DEF_MAX_COLUMNS];
        logic signed [DATA_W-1:0] middle_row [DEF_MAX_COLUMNS];
        logic signed [DATA_W-1:0] west_value;
        int unsigned              col_pos;
        int unsigned              row_pos;
        grid_point_t              expected_points [$];
        int                       errors;

        function new();
            columns_reg = RESET_COLUMNS;
            rows_reg    = RESET_ROWS;
            gain_reg    = RESET_GAIN;
            foreach (upper_row[i])
            begin
                upper_row[i]  = '0;
                middle_row[i] = '0;
            end
            west_value = '0;
            col_pos    = 0;
            row_pos    = 0;
            errors     = 0;
        endfunction

        task report(input string msg);
            if (errors < 100)
                $display("mismatch at %0t: %s", $time, msg);
            errors++;
        endtask

        function int pending();
            return expected_points.size();
        endfunction

        function void set_register(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
            case (idx)
                REG_COLUMNS:
                begin
                    columns_reg = value[COLS_W-1:0];
                    col_pos     = 0;
                    row_pos     = 0;
                end
                REG_ROWS:
                begin
                    rows_reg = value[ROWS_W-1:0];
                    col_pos  = 0;
                    row_pos  = 0;
                end
                REG_GAIN:
                    gain_reg = value[GAIN_W-1:0];
                default:
                    ;
            endcase
        endfunction

        // u + gain*(n+s+e+w-4u), product floored to q16, then saturated
        function logic [DATA_W-1:0] diffuse(input longint centre, input longint north,
                                            input longint south, input longint east,
                                            input longint west);
            longint lap;
            longint prod;
            longint sum;
            longint max_v;
            longint min_v;
            max_v = (longint'(1) <<< (DATA_W - 1)) - 1;
            min_v = -max_v - 1;
            lap   = north + south + east + west - 4 * centre;
            prod  = lap * longint'(gain_reg);
            sum   = centre + (prod >>> FRAC_BITS);
            if (sum > max_v)
                sum = max_v;
            else if (sum < min_v)
                sum = min_v;
            return sum[DATA_W-1:0];
        endfunction

        function void note_request(input logic [DATA_W-1:0] raw);
            int unsigned              cols;
            int unsigned              rows;
            int unsigned              c;
            int unsigned              r;
            logic signed [DATA_W-1:0] v;
            logic signed [DATA_W-1:0] centre;
            grid_point_t              pt;
            cols = (columns_reg < MIN_COLUMNS) ? MIN_COLUMNS : columns_reg;
            if (cols > DEF_MAX_COLUMNS)
                cols = DEF_MAX_COLUMNS;
            rows = (rows_reg < MIN_ROWS) ? MIN_ROWS : rows_reg;
            c = (col_pos >= cols) ? 0 : col_pos;
            r = (row_pos >= rows) ? 0 : row_pos;
            v = raw;
            centre = middle_row[c];
            // each request after the first row releases the point one row above it
            if (r >= 1)
            begin
                if (r == 1 || c == 0 || c + 1 >= cols)
                    pt.value = centre;
                else
                    pt.value = diffuse(centre, upper_row[c], v, middle_row[c+1], west_value);
                pt.frame_end = 1'b0;
                expected_points.push_back(pt);
            end
            west_value    = centre;
            upper_row[c]  = centre;
            middle_row[c] = v;
            // the bottom row also sends itself unchanged
            if (r + 1 == rows)
            begin
                pt.value     = v;
                pt.frame_end = (c + 1 == cols);
                expected_points.push_back(pt);
            end
            if (c + 1 >= cols)
            begin
                col_pos = 0;
                row_pos = (r + 1 >= rows) ? 0 : r + 1;
            end
            else
            begin
                col_pos = c + 1;
                row_pos = r;
            end
        endfunction

        task check_point(input logic [DATA_W-1:0] value, input logic fe);
            grid_point_t exp_pt;
            if (expected_points.size() == 0)
            begin
                report($sformatf("result %h with nothing outstanding", value));
            end
            else
            begin
                exp_pt = expected_points.pop_front();
                if (value !== exp_pt.value)
                    report($sformatf("new_value %h, wanted %h", value, exp_pt.value));
                if (fe !== exp_pt.frame_end)
                    report($sformatf("frame_end %b, wanted %b", fe, exp_pt.frame_end));
            end
        endtask
    endclass

    logic                clk;
    logic                rst_n;
    logic                item_valid;
    logic                item_stall;
    logic [DATA_W-1:0]   old_value;
    logic                result_valid;
    logic                result_stall;
    logic [DATA_W-1:0]   new_value;
    logic                frame_end;
    logic                psel;
    logic                penable;
    logic                pwrite;
    logic [PADDR_W-1:0]  paddr;
    logic [PDATA_W-1:0]  pwdata;
    logic [PDATA_W-1:0]  prdata;
    logic                pready;

    stencil_scoreboard   sb;
    int                  hold_cycles;
    int                  burst_left;
    bit                  no_gaps;
    int                  rx_mode;
    int                  rx_left;

    heat_stencil_5pt_update_top dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .old_value    (old_value),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .new_value    (new_value),
        .frame_end    (frame_end),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    initial
    begin
        clk = 1'b0;
    end

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && item_valid && !item_stall)
            sb.note_request(old_value);
    end

    always @(posedge clk)
    begin
        if (rst_n && result_valid && !result_stall)
            sb.check_point(new_value, frame_end);
    end

    // receiver: stall segments of varying density, plus a long hold-off on demand
    initial
    begin
        result_stall = 1'b0;
        rx_left      = 0;
        rx_mode      = 0;
        forever
        begin
            @(posedge clk);
            if (hold_cycles > 0)
            begin
                result_stall <= 1'b1;
                hold_cycles--;
            end
            else
            begin
                if (rx_left == 0)
                begin
                    rx_mode = $urandom_range(3, 0);
                    rx_left = $urandom_range(80, 10);
                end
                rx_left--;
                case (rx_mode)
                    0:       result_stall <= 1'b0;
                    1:       result_stall <= ($urandom_range(3, 0) == 0);
                    2:       result_stall <= ($urandom_range(9, 0) < 7);
                    default: result_stall <= (rx_left % 3 == 0);
                endcase
            end
        end
    end

    initial
    begin
        #5ms;
        $display("timeout with %0d results outstanding", sb.pending());
        $display("*** FAILED ***");
        $finish;
    end

    function automatic logic [DATA_W-1:0] random_point();
        logic [DATA_W-1:0] v;
        case ($urandom_range(9, 0))
            0:       v = 32'h7FFFFFFF;
            1:       v = 32'h80000000;
            2, 3, 4: v = DATA_W'($signed($urandom_range(2097152, 0)) - 1048576);
            default: v = $urandom;
        endcase
        return v;
    endfunction

    task automatic send_point(input logic [DATA_W-1:0] value);
        int gap;
        gap = 0;
        if (burst_left == 0)
        begin
            burst_left = $urandom_range(40, 1);
            if (!no_gaps && $urandom_range(3, 0) != 0)
                gap = $urandom_range(12, 1);
        end
        burst_left--;
        if (gap > 0)
        begin
            item_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        item_valid <= 1'b1;
        old_value  <= value;
        do
            @(posedge clk);
        while (item_stall);
    endtask

    task automatic send_points(input int count);
        for (int i = 0; i < count; i++)
            send_point(random_point());
    endtask

    // lower valid, then wait out everything in flight, including rows that release nothing
    task automatic drain();
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        repeat (12) @(posedge clk);
    endtask

    task automatic apb_access(input reg_idx_t idx, input logic wr,
                              input logic [PDATA_W-1:0] wdata,
                              output logic [PDATA_W-1:0] rdata);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= PADDR_W'(int'(idx) * 4);
        pwdata  <= wdata;
        @(posedge clk);
        penable <= 1'b1;
        @(negedge clk);
        rdata = prdata;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        @(posedge clk);
    endtask

    task automatic write_register(input reg_idx_t idx, input logic [PDATA_W-1:0] value);
        logic [PDATA_W-1:0] readback;
        logic [PDATA_W-1:0] wanted;
        apb_access(idx, 1'b1, value, readback);
        sb.set_register(idx, value);
        apb_access(idx, 1'b0, '0, readback);
        case (idx)
            REG_COLUMNS: wanted = PDATA_W'(value[COLS_W-1:0]);
            REG_ROWS:    wanted = PDATA_W'(value[ROWS_W-1:0]);
            default:     wanted = PDATA_W'(value[GAIN_W-1:0]);
        endcase
        if (readback !== wanted)
            sb.report($sformatf("register %s read %h, wanted %h", idx.name(), readback, wanted));
    endtask

    task automatic configure(input int cols, input int rows, input int gain);
        write_register(REG_COLUMNS, PDATA_W'(cols));
        write_register(REG_ROWS, PDATA_W'(rows));
        write_register(REG_GAIN, PDATA_W'(gain));
    endtask

    initial
    begin
        int random_sent;
        int cols;
        int rows;
        int eff_cols;
        int eff_rows;
        int gain;
        int count;
        int wait_cycles;

        rst_n       = 1'b0;
        item_valid  = 1'b0;
        old_value   = '0;
        psel        = 1'b0;
        penable     = 1'b0;
        pwrite      = 1'b0;
        paddr       = '0;
        pwdata      = '0;
        hold_cycles = 0;
        burst_left  = 0;
        no_gaps     = 1'b0;
        sb          = new();

        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        configure(3, 3, 65535);
        foreach (EDGE_FRAMES[i])
            send_point(EDGE_FRAMES[i]);
        drain();

        // geometry below the minimum is clamped to 3x3
        configure(0, 0, $urandom_range(65535, 0));
        send_points(27);
        drain();

        // long receiver hold-off while requests keep coming back to back
        configure(5, 4, 16384);
        no_gaps     = 1'b1;
        hold_cycles = 300;
        send_points(80);
        no_gaps = 1'b0;
        drain();

        configure(7, 6, 0);
        send_points(40);
        item_valid <= 1'b0;
        @(posedge clk);
        while (sb.pending() != 0)
            @(posedge clk);
        send_points(44);
        drain();

        // tallest frame, left unfinished; the next geometry write restarts it
        configure(4, 65535, 65535);
        send_points(40);
        drain();

        // oversized column count clamps to the line store depth, seen where row one starts
        configure(2047, 3, $urandom_range(65535, 0));
        send_points(DEF_MAX_COLUMNS + 24);
        drain();

        random_sent = 0;
        while (random_sent < 150)
        begin
            cols = ($urandom_range(4, 0) == 0) ? $urandom_range(64, 17) : $urandom_range(16, 0);
            rows = $urandom_range(8, 0);
            case ($urandom_range(5, 0))
                0:       gain = 0;
                1:       gain = 65535;
                2:       gain = 16384;
                default: gain = $urandom_range(65535, 0);
            endcase
            eff_cols = (cols < MIN_COLUMNS) ? MIN_COLUMNS : cols;
            eff_rows = (rows < 3) ? 3 : rows;
            count = $urandom_range(3, 1) * eff_cols * eff_rows;
            // sometimes stop mid-frame
            if ($urandom_range(1, 0) == 1)
                count += $urandom_range(eff_cols * eff_rows - 1, 0);
            configure(cols, rows, gain);
            send_points(count);
            random_sent += count;
            drain();
        end

        item_valid <= 1'b0;
        wait_cycles = 0;
        while (sb.pending() != 0 && wait_cycles < 20000)
        begin
            @(posedge clk);
            wait_cycles++;
        end
        repeat (20) @(posedge clk);
        if (sb.pending() != 0)
            sb.report($sformatf("%0d results never arrived", sb.pending()));
        if (sb.errors == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
